// File: rtl/kmcs_pkg.sv
// shared constants and types for the key matrix change scanner
package kmcs_pkg;

   localparam int KEY_COUNT  = 128;
   localparam int SCAN_COUNT = (KEY_COUNT > 128) ? 128 : KEY_COUNT;
   localparam int IDX_BITS   = $clog2(SCAN_COUNT);
   localparam int POS_BITS   = 7;
   localparam int GROUP_BITS = 32;
   localparam int LIVE_BITS  = 4 * GROUP_BITS;
   localparam int DATA_BITS  = 16;
   localparam int MASK_BITS  = 8;

   localparam logic [POS_BITS:0] COUNT_LIMIT = (POS_BITS + 1)'(SCAN_COUNT);
   localparam logic [7:0]        READ_HIGH   = 8'hff;
   localparam logic [DATA_BITS-1:0] ACK_EDGE_DATA = 16'hffff;

   localparam logic [1:0] ACT_SCAN = 2'd0;
   localparam logic [1:0] ACT_READ = 2'd1;
   localparam logic [1:0] ACT_MASK = 2'd2;
   localparam logic [1:0] ACT_ACK  = 2'd3;

   typedef struct packed {
      logic load;
      logic shift;
      logic toggle;
   } ring_ctl_type;

   typedef struct packed {
      logic differs;
      logic live_bit;
   } ring_sts_type;

endpackage

// File: rtl/key_matrix_change_scanner.sv
// key matrix change scanner: command decode, scan sequencer and interrupt state
//
// usage: drive req_* and raise start; the item is taken at a clock edge with
// start high and busy low. every item gives exactly one result, shown on
// rsp_read_data and rsp_irq_request for one cycle while rsp_valid is high.
// key read, mask write, acknowledge and a scan tick while scanning is off
// finish at the accepting edge: the result shows in the next cycle and busy
// stays low, so such items may follow each other every cycle.
// a scan tick with scanning on captures the live key bits and walks the
// stored key ring one position per cycle, stopping at the first changed key
// or after a full circle; busy stays high during the walk, then the result shows.
// the walk speed is set by the single compare on bit 0 of the key ring.
// rsp_irq_request is the interrupt level after the item and holds between
// results. the receiver cannot stall; results are never held back.
// reset (synchronous, active high) clears the key states, the position,
// mask and pending bit and turns scanning on; no clearing pass is needed.
module key_matrix_change_scanner (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_action,
   input  logic [kmcs_pkg::GROUP_BITS-1:0] req_key_group0,
   input  logic [kmcs_pkg::GROUP_BITS-1:0] req_key_group1,
   input  logic [kmcs_pkg::GROUP_BITS-1:0] req_key_group2,
   input  logic [kmcs_pkg::GROUP_BITS-1:0] req_key_group3,
   input  logic [kmcs_pkg::MASK_BITS-1:0]  req_mask_value,
   input  logic                            req_line_is_irl,
   output logic                            rsp_valid,
   output logic [kmcs_pkg::DATA_BITS-1:0]  rsp_read_data,
   output logic                            rsp_irq_request
);
   import kmcs_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type             state_ff, state_in;
   logic [POS_BITS-1:0]   pos_ff, pos_in;
   logic [POS_BITS-1:0]   start_pos_ff, start_pos_in;
   logic                  scan_en_ff, scan_en_in;
   logic                  down_ff, down_in;
   logic [MASK_BITS-1:0]  mask_ff, mask_in;
   logic                  pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]  rsp_data_ff, rsp_data_in;
   logic                  rsp_irq_ff, rsp_irq_in;

   logic [POS_BITS-1:0]   pos_inc;
   logic [POS_BITS-1:0]   pos_next;
   ring_ctl_type          ring_ctl;
   ring_sts_type          ring_sts;

   // wrap at the scanned key count
   assign pos_inc  = pos_ff + POS_BITS'(1);
   assign pos_next = ({1'b0, pos_inc} >= COUNT_LIMIT) ? '0 : pos_inc;

   kmcs_key_ring u_ring (
      .clock (clock),
      .reset (reset),
      .ctl   (ring_ctl),
      .live  ({req_key_group3, req_key_group2, req_key_group1, req_key_group0}),
      .idx   (pos_next[IDX_BITS-1:0]),
      .sts   (ring_sts)
   );

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      start_pos_in = start_pos_ff;
      scan_en_in   = scan_en_ff;
      down_in      = down_ff;
      mask_in      = mask_ff;
      pend_in      = pend_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      ring_ctl     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_data_in = '0;
               unique case (req_action)
                  ACT_SCAN: begin
                     if (scan_en_ff) begin
                        ring_ctl.load = 1'b1;
                        start_pos_in  = pos_ff;
                        state_in      = ST_SCAN;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  ACT_READ: begin
                     rsp_data_in  = {READ_HIGH, down_ff, pos_ff};
                     scan_en_in   = 1'b1;
                     pend_in      = 1'b0;
                     rsp_valid_in = 1'b1;
                  end
                  ACT_MASK: begin
                     mask_in      = req_mask_value;
                     rsp_valid_in = 1'b1;
                  end
                  ACT_ACK: begin
                     if (req_line_is_irl) begin
                        rsp_data_in = {READ_HIGH, 7'd0, mask_ff[0] & pend_ff};
                     end else begin
                        rsp_data_in = ACK_EDGE_DATA;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            ring_ctl.shift = 1'b1;
            pos_in         = pos_next;
            rsp_data_in    = '0;
            if (ring_sts.differs) begin
               ring_ctl.toggle = 1'b1;
               down_in         = ring_sts.live_bit;
               scan_en_in      = 1'b0;
               pend_in         = 1'b1;
               rsp_valid_in    = 1'b1;
               state_in        = ST_IDLE;
            end else if (pos_next == start_pos_ff) begin
               // full circle, nothing changed
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      // pending has weight one against the mask
      rsp_irq_in = rsp_valid_in ? (mask_in[0] & pend_in) : rsp_irq_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         scan_en_ff   <= 1'b1;
         down_ff      <= 1'b0;
         mask_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_irq_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         scan_en_ff   <= scan_en_in;
         down_ff      <= down_in;
         mask_ff      <= mask_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_irq_ff   <= rsp_irq_in;
      end
      start_pos_ff <= start_pos_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign busy            = (state_ff == ST_SCAN);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = rsp_data_ff;
   assign rsp_irq_request = rsp_irq_ff;

endmodule

// File: rtl/kmcs_key_ring.sv
// circular shift register of stored key states with captured live bits
module kmcs_key_ring (
   input  logic                          clock,
   input  logic                          reset,
   input  kmcs_pkg::ring_ctl_type        ctl,
   input  logic [kmcs_pkg::LIVE_BITS-1:0] live,
   input  logic [kmcs_pkg::IDX_BITS-1:0] idx,
   output kmcs_pkg::ring_sts_type        sts
);
   import kmcs_pkg::*;

   // bit 0 of mem_ff always holds the key one past the scan position
   logic [SCAN_COUNT-1:0] mem_ff, mem_in;
   logic [SCAN_COUNT-1:0] live_ff, live_in;
   logic                  live_bit;

   assign live_bit = live_ff[idx];

   always_comb begin
      mem_in  = mem_ff;
      live_in = live_ff;
      if (ctl.load) begin
         live_in = live[SCAN_COUNT-1:0];
      end
      if (ctl.shift) begin
         mem_in = {mem_ff[0] ^ ctl.toggle, mem_ff[SCAN_COUNT-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mem_ff <= '0;
      end else begin
         mem_ff <= mem_in;
      end
      live_ff <= live_in;
   end

   assign sts.differs  = mem_ff[0] ^ live_bit;
   assign sts.live_bit = live_bit;

endmodule

// File: rtl/kmcs_checker.sv
// port level checks for the key matrix change scanner, bound to the top level
module kmcs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input logic [1:0]                     req_action,
   input logic                           rsp_valid,
   input logic [kmcs_pkg::DATA_BITS-1:0] rsp_read_data
);
   import kmcs_pkg::*;

   // an item other than a scan tick answers in the very next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_action != ACT_SCAN) |=> rsp_valid)
      else $error("non-scan item gave no result in the next cycle");

   // a key read always reports the all-ones high byte
   assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_action == ACT_READ) |=>
         rsp_valid && (rsp_read_data[15:8] == READ_HIGH))
      else $error("key read result malformed");

   // no result while a scan walk is still running
   assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_valid)
      else $error("result strobe during scan");

   // the end of a scan walk always delivers its item
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("scan walk ended without a result");

endmodule

bind key_matrix_change_scanner kmcs_checker u_kmcs_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_action    (req_action),
   .rsp_valid     (rsp_valid),
   .rsp_read_data (rsp_read_data)
);
